// ===== src/sorted_priority_queue_top_defines.svh =====
// Assertion macros for the sorted priority queue checker.
// Depends on nothing; included by the checker file only.
`ifndef SORTED_PRIORITY_QUEUE_TOP_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_TOP_DEFINES_SVH

// same-cycle implication, disabled in reset
`define SPQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("spq check failed");

// next-cycle implication, disabled in reset
`define SPQ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("spq check failed");

`endif

// ===== src/spq_pkg.sv =====
// Shared types and constants for the sorted priority queue.
// No dependencies.
`default_nettype none
package spq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int ID_W            = 16;
    localparam int TAG_W           = 8;
    localparam int KEY_W           = 32;
    localparam int FILL_W          = 5;
    localparam int ENTRY_W         = ID_W + TAG_W + KEY_W;

    localparam logic CMD_ENQ = 1'b0;
    localparam logic CMD_DEQ = 1'b1;

    typedef enum logic [1:0] {
        ST_ENQUEUED = 2'd0,
        ST_DEQUEUED = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [TAG_W-1:0] tag;
        logic [KEY_W-1:0] key;
    } t_entry;

endpackage
`default_nettype wire

// ===== src/spq_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none
module spq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ===== src/spq_seq.sv =====
// Sequencer for the sorted priority queue: circular buffer pointers, one
// shared key comparator, insertion walk and output register. Uses spq_pkg.
`default_nettype none
module spq_seq #(
    parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEF,
    parameter int AW          = $clog2(QUEUE_DEPTH)
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output      logic                       o_in_ready,
    input  wire logic                       i_command,
    input  wire spq_pkg::t_entry            i_entry,
    output      logic                       o_out_valid,
    input  wire logic                       i_out_ready,
    output      logic [1:0]                 o_status,
    output      spq_pkg::t_entry            o_entry,
    output      logic [spq_pkg::FILL_W-1:0] o_fill_count,
    output      logic                       o_is_empty,
    output      logic                       o_ram_we,
    output      logic [AW-1:0]              o_ram_waddr,
    output      spq_pkg::t_entry            o_ram_wdata,
    output      logic [AW-1:0]              o_ram_raddr,
    input  wire spq_pkg::t_entry            i_ram_rdata
);
    import spq_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_RD   = 5'b00010,
        S_CMP  = 5'b00100,
        S_DEQ  = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    t_state              r_state, n_state;
    t_entry              r_new, n_new;
    t_entry              r_res, n_res;
    t_status             r_status, n_status;
    logic [CW-1:0]       r_j, n_j;
    logic [CW-1:0]       r_count, n_count;
    logic [AW-1:0]       r_head, n_head;
    logic                r_out_valid, n_out_valid;
    t_status             r_out_status, n_out_status;
    t_entry              r_out_ent, n_out_ent;
    logic [FILL_W-1:0]   r_out_fill, n_out_fill;
    logic                r_out_empty, n_out_empty;
    logic                key_gt;

    function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                           input logic [CW-1:0] off);
        logic [AW:0] s;
        s = (AW+1)'(head) + (AW+1)'(off);
        if (s >= (AW+1)'(QUEUE_DEPTH)) begin
            s = s - (AW+1)'(QUEUE_DEPTH);
        end
        return s[AW-1:0];
    endfunction

    assign key_gt = i_ram_rdata.key > r_new.key;

    always_comb begin
        n_state      = r_state;
        n_new        = r_new;
        n_res        = r_res;
        n_status     = r_status;
        n_j          = r_j;
        n_count      = r_count;
        n_head       = r_head;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_status = r_out_status;
        n_out_ent    = r_out_ent;
        n_out_fill   = r_out_fill;
        n_out_empty  = r_out_empty;
        o_ram_we     = 1'b0;
        o_ram_waddr  = phys(r_head, r_j);
        o_ram_wdata  = r_new;
        o_ram_raddr  = phys(r_head, r_j - CW'(1));
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_new = i_entry;
                    n_res = '0;
                    if (i_command == CMD_ENQ) begin
                        if (r_count == CW'(QUEUE_DEPTH)) begin
                            n_status = ST_FULL;
                            n_state  = S_OUT;
                        end else begin
                            n_j     = r_count;
                            n_state = S_RD;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_status = ST_EMPTY;
                            n_state  = S_OUT;
                        end else begin
                            o_ram_raddr = r_head;
                            n_state     = S_DEQ;
                        end
                    end
                end
            end
            S_RD: begin
                if (r_j == '0) begin
                    o_ram_we = 1'b1;
                    n_count  = r_count + CW'(1);
                    n_status = ST_ENQUEUED;
                    n_state  = S_OUT;
                end else begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                o_ram_we = 1'b1;
                if (key_gt) begin
                    o_ram_wdata = i_ram_rdata;
                    n_j         = r_j - CW'(1);
                    n_state     = S_RD;
                end else begin
                    n_count  = r_count + CW'(1);
                    n_status = ST_ENQUEUED;
                    n_state  = S_OUT;
                end
            end
            S_DEQ: begin
                n_res    = i_ram_rdata;
                n_head   = phys(r_head, CW'(1));
                n_count  = r_count - CW'(1);
                n_status = ST_DEQUEUED;
                n_state  = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_ent    = r_res;
                    n_out_fill   = FILL_W'(r_count);
                    n_out_empty  = (r_count == '0);
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_head      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_head      <= n_head;
            r_out_valid <= n_out_valid;
        end
        r_new        <= n_new;
        r_res        <= n_res;
        r_status     <= n_status;
        r_j          <= n_j;
        r_out_status <= n_out_status;
        r_out_ent    <= n_out_ent;
        r_out_fill   <= n_out_fill;
        r_out_empty  <= n_out_empty;
    end

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_status     = r_out_status;
    assign o_entry      = r_out_ent;
    assign o_fill_count = r_out_fill;
    assign o_is_empty   = r_out_empty;

endmodule
`default_nettype wire

// ===== src/sorted_priority_queue_top.sv =====
// Flow: an enqueue walks S_RD and S_CMP from the tail, moving larger keys up;
// a dequeue reads the head in S_DEQ; all results, rejects too, leave via S_OUT.
// Throughput: one item at a time; set by the insertion walk (one RAM read,
// compare and write per moved entry) and output stalls.
// Reset: synchronous, active low; clears count, head, sequencer, output valid.
// Instantiates spq_seq and spq_ram, uses spq_pkg; queue RAM is not cleared.
`default_nettype none
module sorted_priority_queue_top #(
    parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output      logic                       o_in_ready,
    input  wire logic                       i_command,
    input  wire logic [spq_pkg::ID_W-1:0]   i_task_id,
    input  wire logic [spq_pkg::TAG_W-1:0]  i_tag,
    input  wire logic [spq_pkg::KEY_W-1:0]  i_runtime_key,
    output      logic                       o_out_valid,
    input  wire logic                       i_out_ready,
    output      logic [1:0]                 o_status,
    output      logic [spq_pkg::ID_W-1:0]   o_out_task_id,
    output      logic [spq_pkg::TAG_W-1:0]  o_out_tag,
    output      logic [spq_pkg::KEY_W-1:0]  o_out_key,
    output      logic [spq_pkg::FILL_W-1:0] o_fill_count,
    output      logic                       o_is_empty
);
    import spq_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);

    t_entry        in_ent;
    t_entry        out_ent;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [AW-1:0] ram_raddr;
    t_entry        ram_wdata;
    t_entry        ram_rdata;

    assign in_ent = '{id: i_task_id, tag: i_tag, key: i_runtime_key};

    spq_seq #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .AW          (AW)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_command    (i_command),
        .i_entry      (in_ent),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_status     (o_status),
        .o_entry      (out_ent),
        .o_fill_count (o_fill_count),
        .o_is_empty   (o_is_empty),
        .o_ram_we     (ram_we),
        .o_ram_waddr  (ram_waddr),
        .o_ram_wdata  (ram_wdata),
        .o_ram_raddr  (ram_raddr),
        .i_ram_rdata  (ram_rdata)
    );

    spq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_out_task_id = out_ent.id;
    assign o_out_tag     = out_ent.tag;
    assign o_out_key     = out_ent.key;

endmodule
`default_nettype wire

// ===== src/spq_chk.sv =====
// Port-level checker for sorted_priority_queue_top, bound to the top level.
// Uses spq_pkg and sorted_priority_queue_top_defines.svh.
`default_nettype none
`include "sorted_priority_queue_top_defines.svh"
module spq_chk #(
    parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEF
) (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       i_in_valid,
    input wire logic                       o_in_ready,
    input wire logic                       o_out_valid,
    input wire logic                       i_out_ready,
    input wire logic [1:0]                 o_status,
    input wire logic [spq_pkg::ID_W-1:0]   o_out_task_id,
    input wire logic [spq_pkg::TAG_W-1:0]  o_out_tag,
    input wire logic [spq_pkg::KEY_W-1:0]  o_out_key,
    input wire logic [spq_pkg::FILL_W-1:0] o_fill_count,
    input wire logic                       o_is_empty
);
    import spq_pkg::*;

    logic                        in_acc;
    logic                        stalled;
    logic [ENTRY_W+FILL_W+2:0]   out_bits;
    logic                        not_deq;
    logic                        res_zero;
    logic                        full_res;

    assign in_acc   = i_in_valid && o_in_ready;
    assign stalled  = o_out_valid && !i_out_ready;
    assign out_bits = {o_status, o_out_task_id, o_out_tag, o_out_key, o_fill_count, o_is_empty};
    assign not_deq  = o_out_valid && (o_status != ST_DEQUEUED);
    assign res_zero = (o_out_task_id == '0) && (o_out_tag == '0) && (o_out_key == '0);
    assign full_res = o_out_valid && (o_status == ST_FULL);

    // a stalled item holds
    `SPQ_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, stalled, o_out_valid && $stable(out_bits))
    // accepted item is busy next cycle
    `SPQ_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, in_acc, !o_in_ready)
    `SPQ_ASSERT_IMP(a_empty_flag, i_clk, i_rst_n, o_out_valid, o_is_empty == (o_fill_count == '0))
    `SPQ_ASSERT_IMP(a_non_deq_zero, i_clk, i_rst_n, not_deq, res_zero)
    `SPQ_ASSERT_IMP(a_full_count, i_clk, i_rst_n, full_res, o_fill_count == FILL_W'(QUEUE_DEPTH))

endmodule

bind sorted_priority_queue_top spq_chk #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_chk (.*);
`default_nettype wire
